/* sv/sal_pkg.sv */
// ----------------------------------------------------------------------------
// sal_pkg
// Shared widths and the distance calibration table for the sensor
// average and linearize block.
// ----------------------------------------------------------------------------
package sal_pkg;

  localparam int ReadW   = 10;
  localparam int TenthW  = 10;
  localparam int ProdW   = ReadW + TenthW;
  localparam int CalSize = 11;
  localparam int CalIdxW = $clog2(CalSize);

  // descending readings with their distances in tenths of a centimeter
  localparam logic [ReadW-1:0] CalReading [CalSize] = '{
    10'd471, 10'd338, 10'd266, 10'd225, 10'd194, 10'd170,
    10'd153, 10'd123, 10'd102, 10'd90,  10'd82
  };

  localparam logic [TenthW-1:0] CalTenths [CalSize] = '{
    10'd100, 10'd150, 10'd200, 10'd250, 10'd300, 10'd350,
    10'd400, 10'd500, 10'd600, 10'd700, 10'd800
  };

endpackage

/* sv/sensor_average_and_linearize.sv */
// ----------------------------------------------------------------------------
// sensor_average_and_linearize
// Moving average of converter samples mapped to distance by piecewise
// linear interpolation over a calibration table.
//
//   channel   handshake        ports
//   input     push / full      sample_i
//   result    pop / empty      filtered_o, distance_tenths_o, in_range_o
//
// The front takes a new sample only when idle again after the ring read,
// update and request push steps. The back works off one request at a time
// (mean, range check, segment search, interpolation), sharing a single
// bit-serial divider between the mean and the interpolation. A two-entry
// queue lets the front go on while the back or the result side stalls.
// Reset clears sum, count and position; no clearing pass.
// ----------------------------------------------------------------------------
module sensor_average_and_linearize #(
  parameter int WINDOW       = 10,
  parameter int TABLE_POINTS = 11
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [sal_pkg::ReadW-1:0]    sample_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [sal_pkg::ReadW-1:0]    filtered_o,
  output logic [sal_pkg::TenthW-1:0]   distance_tenths_o,
  output logic                         in_range_o
);

  import sal_pkg::*;

  localparam int ReqW = ReadW + $clog2(WINDOW) + $clog2(WINDOW + 1);

  logic            req_push;
  logic            req_full;
  logic [ReqW-1:0] req_wdata;
  logic            req_pop;
  logic            req_empty;
  logic [ReqW-1:0] req_rdata;

  sal_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .sample_i   (sample_i),
    .full_o     (full),
    .req_push_o (req_push),
    .req_data_o (req_wdata),
    .req_full_i (req_full)
  );

  sal_fifo #(
    .DataW (ReqW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (req_push),
    .data_i  (req_wdata),
    .full_o  (req_full),
    .pop_i   (req_pop),
    .data_o  (req_rdata),
    .empty_o (req_empty)
  );

  sal_back #(
    .WINDOW       (WINDOW),
    .TABLE_POINTS (TABLE_POINTS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .req_data_i        (req_rdata),
    .req_empty_i       (req_empty),
    .req_pop_o         (req_pop),
    .empty_o           (empty),
    .pop_i             (pop),
    .filtered_o        (filtered_o),
    .distance_tenths_o (distance_tenths_o),
    .in_range_o        (in_range_o)
  );

endmodule

/* sv/sal_fifo.sv */
// ----------------------------------------------------------------------------
// sal_fifo
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module sal_fifo #(
  parameter int DataW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [DataW-1:0] data_o,
  output logic             empty_o
);

  logic [DataW-1:0] entry_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* sv/sal_front.sv */
// ----------------------------------------------------------------------------
// sal_front
// Takes samples, keeps the sample ring, running sum and fill count, and
// queues a divide request of sum and count for each sample.
// ----------------------------------------------------------------------------
module sal_front #(
  parameter int WINDOW = 10
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    push_i,
  input  logic [sal_pkg::ReadW-1:0]               sample_i,
  output logic                                    full_o,
  output logic                                    req_push_o,
  output logic [sal_pkg::ReadW+$clog2(WINDOW)+$clog2(WINDOW+1)-1:0] req_data_o,
  input  logic                                    req_full_i
);

  import sal_pkg::*;

  localparam int SumW = ReadW + $clog2(WINDOW);
  localparam int CntW = $clog2(WINDOW + 1);
  localparam int PosW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  typedef enum logic [1:0] {
    F_IDLE,
    F_READ,
    F_UPDATE,
    F_PUSH
  } front_state_e;

  front_state_e     state_q;
  logic [ReadW-1:0] ring_q [WINDOW];
  logic [ReadW-1:0] sample_q;
  logic [ReadW-1:0] old_q;
  logic [SumW-1:0]  sum_q;
  logic [CntW-1:0]  cnt_q;
  logic [PosW-1:0]  pos_q;
  logic             ring_full;

  assign full_o     = (state_q != F_IDLE);
  assign req_push_o = (state_q == F_PUSH);
  assign req_data_o = {sum_q, cnt_q};
  assign ring_full  = (cnt_q == CntW'(WINDOW));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      sum_q   <= '0;
      cnt_q   <= '0;
      pos_q   <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (push_i) begin
            state_q <= F_READ;
          end
        end
        F_READ: begin
          state_q <= F_UPDATE;
        end
        F_UPDATE: begin
          if (ring_full) begin
            sum_q <= sum_q - SumW'(old_q) + SumW'(sample_q);
          end else begin
            sum_q <= sum_q + SumW'(sample_q);
            cnt_q <= cnt_q + 1'b1;
          end
          if (pos_q == PosW'(WINDOW - 1)) begin
            pos_q <= '0;
          end else begin
            pos_q <= pos_q + 1'b1;
          end
          state_q <= F_PUSH;
        end
        F_PUSH: begin
          if (!req_full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: begin
          state_q <= F_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && push_i) begin
      sample_q <= sample_i;
    end
    if (state_q == F_READ) begin
      old_q <= ring_q[pos_q];
    end
    if (state_q == F_UPDATE) begin
      ring_q[pos_q] <= sample_q;
    end
  end

endmodule

/* sv/sal_div.sv */
// ----------------------------------------------------------------------------
// sal_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sal_div #(
  parameter int NumW = 20,
  parameter int DenW = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);

  localparam int StepW = $clog2(NumW + 1);

  logic [StepW-1:0] step_q;
  logic             done_q;
  logic [NumW-1:0]  num_q;
  logic [NumW-1:0]  quo_q;
  logic [DenW-1:0]  den_q;
  logic [DenW-1:0]  rem_q;
  logic [DenW:0]    rem_shift;
  logic [DenW:0]    rem_sub;
  logic             fits;

  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_comb begin
    rem_shift = {rem_q, num_q[NumW-1]};
    rem_sub   = rem_shift - {1'b0, den_q};
    fits      = (rem_shift >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        step_q <= StepW'(NumW);
      end else if (step_q != '0) begin
        step_q <= step_q - 1'b1;
        done_q <= (step_q == StepW'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (step_q != '0) begin
      num_q <= {num_q[NumW-2:0], 1'b0};
      quo_q <= {quo_q[NumW-2:0], fits};
      rem_q <= fits ? rem_sub[DenW-1:0] : rem_shift[DenW-1:0];
    end
  end

endmodule

/* sv/sal_back.sv */
// ----------------------------------------------------------------------------
// sal_back
// Works off queued requests: rounded mean by division, segment search in
// the calibration table, interpolation, and the result register.
// ----------------------------------------------------------------------------
module sal_back #(
  parameter int WINDOW       = 10,
  parameter int TABLE_POINTS = 11
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic [sal_pkg::ReadW+$clog2(WINDOW)+$clog2(WINDOW+1)-1:0] req_data_i,
  input  logic                                    req_empty_i,
  output logic                                    req_pop_o,
  output logic                                    empty_o,
  input  logic                                    pop_i,
  output logic [sal_pkg::ReadW-1:0]               filtered_o,
  output logic [sal_pkg::TenthW-1:0]              distance_tenths_o,
  output logic                                    in_range_o
);

  import sal_pkg::*;

  localparam int SumW    = ReadW + $clog2(WINDOW);
  localparam int CntW    = $clog2(WINDOW + 1);
  localparam int DivNW   = (SumW > ProdW) ? SumW : ProdW;
  localparam int DivDW   = (CntW > ReadW) ? CntW : ReadW;
  localparam int UsedPts = (TABLE_POINTS < CalSize) ? TABLE_POINTS : CalSize;
  localparam int SegW    = $clog2(UsedPts);
  localparam logic [CalIdxW-1:0] LastIdx = CalIdxW'(UsedPts - 1);

  typedef enum logic [2:0] {
    B_IDLE,
    B_MEAN,
    B_RANGE,
    B_SEARCH,
    B_MUL,
    B_INTERP,
    B_OUT
  } back_state_e;

  back_state_e       state_q;
  logic              out_valid_q;
  logic [ReadW-1:0]  mean_q;
  logic [TenthW-1:0] dist_q;
  logic              ok_q;
  logic [SegW-1:0]   seg_q;
  logic [ProdW-1:0]  prod_q;
  logic [ReadW-1:0]  span_q;
  logic [TenthW-1:0] near_q;

  logic [SumW-1:0]   job_sum;
  logic [CntW-1:0]   job_cnt;
  logic [SegW-1:0]   seg_nx;
  logic [ReadW-1:0]  hi_c, lo_c;
  logic [TenthW-1:0] dn_c, df_c;
  logic [ReadW-1:0]  dv_c;
  logic [TenthW-1:0] dt_c;
  logic [ProdW-1:0]  prod_c;

  logic              div_start;
  logic [DivNW-1:0]  div_num;
  logic [DivDW-1:0]  div_den;
  logic              div_done;
  logic [DivNW-1:0]  div_quo;

  assign {job_sum, job_cnt} = req_data_i;
  assign req_pop_o = (state_q == B_IDLE) && !req_empty_i;
  assign div_start = req_pop_o || (state_q == B_MUL);
  assign empty_o   = !out_valid_q;

  always_comb begin
    if (state_q == B_IDLE) begin
      div_num = DivNW'(job_sum + SumW'(job_cnt >> 1));
      div_den = DivDW'(job_cnt);
    end else begin
      div_num = DivNW'(prod_q);
      div_den = DivDW'(span_q);
    end
  end

  always_comb begin
    seg_nx = seg_q + 1'b1;
    hi_c   = CalReading[CalIdxW'(seg_q)];
    lo_c   = CalReading[CalIdxW'(seg_nx)];
    dn_c   = CalTenths[CalIdxW'(seg_q)];
    df_c   = CalTenths[CalIdxW'(seg_nx)];
    dv_c   = hi_c - mean_q;
    dt_c   = df_c - dn_c;
    prod_c = ProdW'(dv_c) * ProdW'(dt_c);
  end

  sal_div #(
    .NumW (DivNW),
    .DenW (DivDW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= B_IDLE;
      out_valid_q       <= 1'b0;
      filtered_o        <= '0;
      distance_tenths_o <= '0;
      in_range_o        <= 1'b0;
    end else begin
      if (pop_i && out_valid_q && state_q != B_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (!req_empty_i) begin
            state_q <= B_MEAN;
          end
        end
        B_MEAN: begin
          if (div_done) begin
            state_q <= B_RANGE;
          end
        end
        B_RANGE: begin
          if (mean_q > CalReading[0] || mean_q < CalReading[LastIdx]) begin
            state_q <= B_OUT;
          end else begin
            state_q <= B_SEARCH;
          end
        end
        B_SEARCH: begin
          if (mean_q >= lo_c) begin
            state_q <= B_MUL;
          end
        end
        B_MUL: begin
          state_q <= B_INTERP;
        end
        B_INTERP: begin
          if (div_done) begin
            state_q <= B_OUT;
          end
        end
        B_OUT: begin
          if (!out_valid_q || pop_i) begin
            out_valid_q       <= 1'b1;
            filtered_o        <= mean_q;
            distance_tenths_o <= dist_q;
            in_range_o        <= ok_q;
            state_q           <= B_IDLE;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_MEAN && div_done) begin
      mean_q <= div_quo[ReadW-1:0];
    end
    if (state_q == B_RANGE) begin
      seg_q  <= '0;
      ok_q   <= 1'b0;
      dist_q <= '0;
    end
    if (state_q == B_SEARCH) begin
      if (mean_q >= lo_c) begin
        prod_q <= prod_c;
        span_q <= hi_c - lo_c;
        near_q <= dn_c;
      end else begin
        seg_q <= seg_nx;
      end
    end
    if (state_q == B_INTERP && div_done) begin
      dist_q <= near_q + div_quo[TenthW-1:0];
      ok_q   <= 1'b1;
    end
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sensor_average_and_linearize. Samples go in
// through the push side and results are drained through the pop side,
// both with random idle bursts. A scoreboard keeps its own window, sum
// and fill count, predicts the rounded mean and the interpolated
// distance for every accepted sample, and compares each popped result
// field by field. Directed samples cover the table ends, the extremes
// and both out-of-span sides. Random runs settle near table levels so
// most means land inside the calibration span.
// ----------------------------------------------------------------------------
module tb_top;

  import sal_pkg::*;

  typedef struct packed {
    logic [ReadW-1:0]  filtered;
    logic [TenthW-1:0] tenths;
    logic              in_range;
  } reading_t;

  class distance_tracker;
    localparam int WindowLen = 10;
    localparam int Points    = 11;

    logic [ReadW-1:0] ring [WindowLen];
    logic [13:0]      sum    = '0;
    int unsigned      slot   = 0;
    int unsigned      held   = 0;
    int unsigned      errors = 0;
    reading_t         expected_readings [$];

    function reading_t average_and_map(logic [ReadW-1:0] s);
      reading_t    r;
      int unsigned mean, hi, lo, dn, df;
      r = '0;
      if (held >= WindowLen) sum -= 14'(ring[slot]);
      else held++;
      ring[slot] = s;
      sum += 14'(s);
      slot = (slot + 1 == WindowLen) ? 0 : slot + 1;
      mean = (32'(sum) + held / 2) / held;
      r.filtered = mean[ReadW-1:0];
      if (mean <= CalReading[0] && mean >= CalReading[Points-1]) begin
        for (int i = 0; i + 1 < Points; i++) begin
          hi = CalReading[i];
          lo = CalReading[i+1];
          if (!r.in_range && mean <= hi && mean >= lo) begin
            dn = CalTenths[i];
            df = CalTenths[i+1];
            r.in_range = 1'b1;
            r.tenths = TenthW'(dn + ((hi - mean) * (df - dn)) / (hi - lo));
          end
        end
      end
      return r;
    endfunction

    function void note_sample(logic [ReadW-1:0] s);
      expected_readings.push_back(average_and_map(s));
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected result filtered=%0d tenths=%0d in_range=%0d",
                 $time, got.filtered, got.tenths, got.in_range);
        errors++;
        return;
      end
      want = expected_readings.pop_front();
      if (got.filtered !== want.filtered) begin
        $display("%0t: filtered expected %0d actual %0d", $time, want.filtered,
                 got.filtered);
        errors++;
      end
      if (got.tenths !== want.tenths) begin
        $display("%0t: distance_tenths expected %0d actual %0d", $time, want.tenths,
                 got.tenths);
        errors++;
      end
      if (got.in_range !== want.in_range) begin
        $display("%0t: in_range expected %0d actual %0d", $time, want.in_range,
                 got.in_range);
        errors++;
      end
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction
  endclass

  localparam int CycleLimit  = 600000;
  localparam int RandomItems = 1927;
  localparam int HoldOffLen  = 400;

  localparam logic [ReadW-1:0] DirectedSamples [23] = '{
    10'd471, 10'd1023, 10'd0,
    10'd82, 10'd82, 10'd82, 10'd82, 10'd82, 10'd82, 10'd82, 10'd82, 10'd82, 10'd82,
    10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd1023
  };

  logic              clk_i    = 1'b0;
  logic              rst_ni   = 1'b0;
  logic              push     = 1'b0;
  logic              pop      = 1'b0;
  logic [ReadW-1:0]  sample_i = '0;
  logic              full;
  logic              empty;
  logic [ReadW-1:0]  filtered_o;
  logic [TenthW-1:0] distance_tenths_o;
  logic              in_range_o;

  distance_tracker board = new();
  int unsigned     samples_taken = 0;
  int unsigned     cycles        = 0;
  bit              quiet         = 1'b0;

  sensor_average_and_linearize u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .sample_i          (sample_i),
    .empty             (empty),
    .pop               (pop),
    .filtered_o        (filtered_o),
    .distance_tenths_o (distance_tenths_o),
    .in_range_o        (in_range_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && push && !full) begin
      board.note_sample(sample_i);
      samples_taken++;
    end
    if (rst_ni && pop && !empty) begin
      board.check_reading('{filtered_o, distance_tenths_o, in_range_o});
    end
  end

  task automatic send_sample(input logic [ReadW-1:0] s);
    push     <= 1'b1;
    sample_i <= s;
    do @(posedge clk_i); while (full);
  endtask

  task automatic idle_push(input int n);
    push <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  task automatic random_stimulus(input int total);
    int idx, len, base, spread, mode, v;
    idx = 0;
    while (idx < total) begin
      mode   = $urandom_range(0, 9);
      len    = $urandom_range(5, 30);
      spread = $urandom_range(0, 20);
      base   = $urandom_range(70, 480);
      case (mode)
        6: begin
          // steady run on a table point, mean hits it exactly
          base   = CalReading[$urandom_range(0, CalSize - 1)];
          spread = 0;
          len    = 12;
        end
        7: begin
          base   = 512;
          spread = 512;
        end
        9: begin
          base   = $urandom_range(0, 1) ? $urandom_range(462, 480) : $urandom_range(74, 90);
          spread = 8;
        end
        default: ;
      endcase
      for (int k = 0; k < len && idx < total; k++) begin
        if (idx == total / 2) wait_drained();
        if (idx == total - 250) quiet = 1'b1;
        v = base + int'($urandom_range(0, 2 * spread)) - spread;
        if (mode == 8) v = $urandom_range(0, 1) ? 1023 : 0;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        if (!quiet && $urandom_range(0, 7) == 0) idle_push($urandom_range(1, 3));
        send_sample(v[ReadW-1:0]);
        idx++;
      end
    end
  endtask

  // result side: random stalls plus one long hold-off to back up the input
  initial begin
    bit held_off;
    held_off = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held_off && samples_taken >= 400) begin
        pop <= 1'b0;
        repeat (HoldOffLen) @(posedge clk_i);
        held_off = 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (DirectedSamples[i]) begin
      if ($urandom_range(0, 3) == 0) idle_push($urandom_range(1, 3));
      send_sample(DirectedSamples[i]);
    end
    random_stimulus(RandomItems);
    wait_drained();
    repeat (100) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
